// ===== sv/dr_pkg.sv =====
// ----------------------------------------------------------------------------
// dr_pkg
// shared types and constants for the difficulty retarget block
// ----------------------------------------------------------------------------
package dr_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [2:0] CSR_NO_RETARGET = 3'd0;
   localparam logic [2:0] CSR_TIMESPAN    = 3'd1;
   localparam logic [2:0] CSR_LIMIT_0     = 3'd2;
   localparam logic [2:0] CSR_LIMIT_1     = 3'd3;
   localparam logic [2:0] CSR_LIMIT_2     = 3'd4;
   localparam logic [2:0] CSR_LIMIT_3     = 3'd5;

   // classified request handed from front to back
   typedef struct packed {
      logic        bypass;
      logic [31:0] bits;
      logic        zero_ts;
      logic        kill;
      logic [4:0]  byte_sh;
      logic [54:0] product;
   } entry_type;

   typedef struct packed {
      logic busy;
   } back_status_type;

endpackage

// ===== sv/dr_front.sv =====
// ----------------------------------------------------------------------------
// dr_front
// accepts requests, clamps the window span, splits the compact word and
// multiplies the mantissa by the span
// ----------------------------------------------------------------------------
module dr_front import dr_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_push,
   output logic            req_full,
   input  logic [31:0]     req_last_bits,
   input  logic [31:0]     req_last_block_time,
   input  logic [31:0]     req_first_block_time,
   input  logic            no_retarget,
   input  logic [29:0]     target_timespan,
   input  logic            q_full,
   output logic            q_push,
   output entry_type       q_data
);

   logic        vld_ff, vld_in;
   logic        bypass_ff, zero_ts_ff, kill_ff;
   logic [31:0] bits_ff;
   logic [22:0] mant_ff, mant_in;
   logic [31:0] span_ff, span_in;
   logic [4:0]  sh_ff, sh_in;
   logic        kill_in;
   logic        accept;
   logic [32:0] diff;
   logic [31:0] lo, hi;
   logic [7:0]  size;
   logic [7:0]  size_m3;

   assign accept   = req_push && !req_full;
   assign req_full = vld_ff && q_full;
   assign q_push   = vld_ff && !q_full;
   assign vld_in   = accept || (vld_ff && q_full);

   assign diff    = {1'b0, req_last_block_time} - {1'b0, req_first_block_time};
   assign lo      = {4'd0, target_timespan[29:2]};
   assign hi      = {target_timespan, 2'b00};
   assign size    = req_last_bits[31:24];
   assign size_m3 = size - 8'd3;

   always_comb begin
      if (diff[32] || diff[31:0] < lo) begin
         span_in = lo;
      end else if (diff[31:0] > hi) begin
         span_in = hi;
      end else begin
         span_in = diff[31:0];
      end
      if (size <= 8'd3) begin
         mant_in = req_last_bits[22:0] >> {3'd3 - {1'b0, size[1:0]}, 3'b000};
         sh_in   = 5'd0;
         kill_in = 1'b0;
      end else begin
         mant_in = req_last_bits[22:0];
         sh_in   = size_m3[4:0];
         kill_in = (size_m3 >= 8'd32);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      if (accept) begin
         bits_ff    <= req_last_bits;
         bypass_ff  <= no_retarget;
         zero_ts_ff <= (target_timespan == 30'd0);
         kill_ff    <= kill_in;
         mant_ff    <= mant_in;
         span_ff    <= span_in;
         sh_ff      <= sh_in;
      end
   end

   always_comb begin
      q_data.bypass  = bypass_ff;
      q_data.bits    = bits_ff;
      q_data.zero_ts = zero_ts_ff;
      q_data.kill    = kill_ff;
      q_data.byte_sh = sh_ff;
      q_data.product = 55'(mant_ff * span_ff);
   end

endmodule

// ===== sv/dr_queue.sv =====
// ----------------------------------------------------------------------------
// dr_queue
// short queue between front and back
// ----------------------------------------------------------------------------
module dr_queue import dr_pkg::*; #(
   parameter int Depth = QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   output logic      full,
   input  logic      pop,
   output entry_type pop_data,
   output logic      empty
);

   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CW = $clog2(Depth + 1);

   entry_type     mem [Depth];
   logic [AW-1:0] wr_ff, rd_ff;
   logic [CW-1:0] cnt_ff;

   assign full     = (cnt_ff == CW'(Depth));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_data;
      end
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == AW'(Depth - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= (rd_ff == AW'(Depth - 1)) ? '0 : rd_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + CW'(push) - CW'(pop);
      end
   end

endmodule

// ===== sv/dr_back.sv =====
// ----------------------------------------------------------------------------
// dr_back
// bit-serial long division by the timespan, limit compare and compact encode
// ----------------------------------------------------------------------------
module dr_back import dr_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_empty,
   input  entry_type       q_data,
   output logic            q_pop,
   input  logic [29:0]     target_timespan,
   input  logic [255:0]    limit,
   output back_status_type status,
   output logic            rsp_empty,
   input  logic            rsp_pop,
   output logic [31:0]     rsp_new_bits
);

   typedef enum logic [1:0] {IDLE, DIVIDE, FINISH} state_type;

   state_type    state_ff;
   logic [7:0]   cnt_ff;
   logic [255:0] div_ff, quo_ff;
   logic [29:0]  rem_ff;
   logic         gt_ff, lt_ff, qseen_ff, lseen_ff, zero_ts_ff;
   logic [8:0]   qlen_ff, llen_ff;
   logic         rvld_ff;
   logic [31:0]  rbits_ff;

   logic         res_free;
   logic         rsp_load;
   logic [30:0]  cur;
   logic         qbit, lbit;
   logic [30:0]  cur_sub;
   logic         cap;
   logic [255:0] val;
   logic [8:0]   vlen;
   logic [5:0]   size;
   logic [279:0] win;
   logic [23:0]  c;
   logic [31:0]  enc;
   logic [255:0] load_div;

   assign res_free     = !rvld_ff || rsp_pop;
   assign rsp_empty    = !rvld_ff;
   assign rsp_new_bits = rbits_ff;
   assign status.busy  = (state_ff != IDLE);
   assign q_pop        = (state_ff == IDLE) && !q_empty && (!q_data.bypass || res_free);
   assign rsp_load     = ((state_ff == IDLE) && q_pop && q_data.bypass) ||
                         ((state_ff == FINISH) && res_free);

   assign load_div = q_data.kill ? '0 : ({201'd0, q_data.product} << {q_data.byte_sh, 3'b000});

   assign cur     = {rem_ff, div_ff[255]};
   assign qbit    = (cur >= {1'b0, target_timespan});
   assign cur_sub = cur - {1'b0, target_timespan};
   assign lbit    = limit[~cnt_ff];

   always_comb begin
      cap  = gt_ff || zero_ts_ff;
      val  = cap ? limit : quo_ff;
      vlen = cap ? llen_ff : qlen_ff;
      size = 6'((vlen + 9'd7) >> 3);
      win  = {val, 24'd0} >> {size, 3'b000};
      c    = win[23:0];
      if (c[23]) begin
         enc = {2'b00, 6'(size + 6'd1), 8'd0, c[23:8]};
      end else begin
         enc = {2'b00, size, c};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         rvld_ff  <= 1'b0;
      end else begin
         if (rsp_pop && rvld_ff && !rsp_load) begin
            rvld_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               if (q_pop) begin
                  if (q_data.bypass) begin
                     rvld_ff  <= 1'b1;
                     rbits_ff <= q_data.bits;
                  end else begin
                     state_ff   <= DIVIDE;
                     cnt_ff     <= 8'd0;
                     div_ff     <= load_div;
                     rem_ff     <= '0;
                     gt_ff      <= 1'b0;
                     lt_ff      <= 1'b0;
                     qseen_ff   <= 1'b0;
                     lseen_ff   <= 1'b0;
                     qlen_ff    <= '0;
                     llen_ff    <= '0;
                     zero_ts_ff <= q_data.zero_ts;
                  end
               end
            end
            DIVIDE: begin
               div_ff <= {div_ff[254:0], 1'b0};
               quo_ff <= {quo_ff[254:0], qbit};
               rem_ff <= qbit ? cur_sub[29:0] : cur[29:0];
               if (!gt_ff && !lt_ff && (qbit != lbit)) begin
                  gt_ff <= qbit;
                  lt_ff <= lbit;
               end
               if (qbit && !qseen_ff) begin
                  qseen_ff <= 1'b1;
                  qlen_ff  <= 9'd256 - {1'b0, cnt_ff};
               end
               if (lbit && !lseen_ff) begin
                  lseen_ff <= 1'b1;
                  llen_ff  <= 9'd256 - {1'b0, cnt_ff};
               end
               cnt_ff <= cnt_ff + 8'd1;
               if (cnt_ff == 8'd255) begin
                  state_ff <= FINISH;
               end
            end
            FINISH: begin
               if (res_free) begin
                  rvld_ff  <= 1'b1;
                  rbits_ff <= enc;
                  state_ff <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

endmodule

// ===== sv/difficulty_retarget.sv =====
// ----------------------------------------------------------------------------
// difficulty_retarget
// compact target retarget: clamp span, scale target, divide, cap, re-encode
//
//   channel  ports                                   direction
//   request  req_push/req_full, req_* fields         in
//   result   rsp_empty/rsp_pop, rsp_new_bits         out
//   csr      csr_wr_en, csr_index, csr_wdata         in
//
// a retarget request is held in the back end by the one bit per cycle long
// division over 256 bits; a request with retargeting off skips the division;
// the front accepts one request a cycle until the queue between front and
// back fills; reset is synchronous and clears the queue and all control state
// a result waiting on rsp_pop stalls the back end in its final step, and
// holds a request with retargeting off in the queue
// ----------------------------------------------------------------------------
module difficulty_retarget import dr_pkg::*; #(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [31:0] req_last_bits,
   input  logic [31:0] req_last_block_time,
   input  logic [31:0] req_first_block_time,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_new_bits,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   logic            no_retarget_ff;
   logic [29:0]     timespan_ff;
   logic [63:0]     limit_ff [4];
   logic [255:0]    limit;
   logic            q_push, q_full, q_pop, q_empty;
   entry_type       q_in, q_out;
   back_status_type back_st;

   assign limit = {limit_ff[3], limit_ff[2], limit_ff[1], limit_ff[0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         no_retarget_ff <= 1'b0;
         timespan_ff    <= 30'd7200;
         limit_ff[0]    <= '1;
         limit_ff[1]    <= '1;
         limit_ff[2]    <= '1;
         limit_ff[3]    <= 64'h0000_0000_FFFF_FFFF;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_NO_RETARGET: no_retarget_ff <= csr_wdata[0];
            CSR_TIMESPAN:    timespan_ff    <= csr_wdata[29:0];
            CSR_LIMIT_0:     limit_ff[0]    <= csr_wdata;
            CSR_LIMIT_1:     limit_ff[1]    <= csr_wdata;
            CSR_LIMIT_2:     limit_ff[2]    <= csr_wdata;
            CSR_LIMIT_3:     limit_ff[3]    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   dr_front u_front (
      .clock                (clock),
      .reset                (reset),
      .req_push             (req_push),
      .req_full             (req_full),
      .req_last_bits        (req_last_bits),
      .req_last_block_time  (req_last_block_time),
      .req_first_block_time (req_first_block_time),
      .no_retarget          (no_retarget_ff),
      .target_timespan      (timespan_ff),
      .q_full               (q_full),
      .q_push               (q_push),
      .q_data               (q_in)
   );

   dr_queue #(.Depth(QueueDepth)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   dr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_data          (q_out),
      .q_pop           (q_pop),
      .target_timespan (timespan_ff),
      .limit           (limit),
      .status          (back_st),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_new_bits    (rsp_new_bits)
   );

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !back_st.busy) else $error("queue popped while back end busy");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full) else $error("queue pushed while full");

   a_pop_data: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty) else $error("queue popped while empty");

endmodule

// ===== dv/tb_difficulty_retarget.sv =====
// ----------------------------------------------------------------------------
// tb_difficulty_retarget
// self-checking bench for the compact target retarget block
//
// requests go in through the push/full queue port in bursts with random
// gaps; results are popped with random stalls and one long hold-off.
// a scoreboard works out every new compact word from its own copy of the
// csr settings and compares it with the popped result, oldest first.
// csr settings are changed only once every result has come back.
// ----------------------------------------------------------------------------
module tb_difficulty_retarget;
   import dr_pkg::*;

   localparam logic [2:0] CSR_UNUSED = 3'd6;
   localparam int         BACK_LAT   = 300;
   localparam longint     MAX_CYCLES = 3000000;

   class retarget_scoreboard;
      bit          no_retarget;
      logic [29:0] timespan;
      logic [255:0] limit;
      logic [31:0] pending_bits[$];
      int          errors;

      function new();
         no_retarget = 1'b0;
         timespan    = 30'd7200;
         limit       = {64'h0000_0000_ffff_ffff, {192{1'b1}}};
         errors      = 0;
      endfunction

      function logic [31:0] encode(logic [255:0] t);
         int          blen;
         int          sz;
         logic [31:0] c;
         logic [255:0] s;
         blen = 0;
         for (int i = 255; i >= 0; i--) begin
            if (t[i] && blen == 0) blen = i + 1;
         end
         sz = (blen + 7) / 8;
         if (sz <= 3) begin
            c = (t[31:0] << (8 * (3 - sz))) & 32'h00ff_ffff;
         end else begin
            s = t >> (8 * (sz - 3));
            c = {8'd0, s[23:0]};
         end
         if (c[23]) begin
            c = c >> 8;
            sz++;
         end
         return c | (32'(sz) << 24);
      endfunction

      function logic [31:0] retarget(logic [31:0] bits, logic [31:0] last_t,
                                     logic [31:0] first_t);
         longint       span;
         longint       lo;
         longint       hi;
         int           sz;
         logic [255:0] t;
         if (no_retarget) return bits;
         span = longint'({32'd0, last_t}) - longint'({32'd0, first_t});
         lo   = longint'(timespan / 4);
         hi   = longint'(timespan) * 4;
         if (span < lo) span = lo;
         if (span > hi) span = hi;
         if (timespan == 0) return encode(limit);
         sz = bits[31:24];
         if (sz <= 3) t = 256'(bits[22:0] >> (8 * (3 - sz)));
         else if (sz - 3 >= 32) t = '0;
         else t = 256'(bits[22:0]) << (8 * (sz - 3));
         t = t * 256'(span);
         t = t / 256'(timespan);
         if (t > limit) t = limit;
         return encode(t);
      endfunction

      function void note(logic [31:0] bits, logic [31:0] last_t, logic [31:0] first_t);
         pending_bits.push_back(retarget(bits, last_t, first_t));
      endfunction

      function void check(logic [31:0] got);
         logic [31:0] want;
         if (pending_bits.size() == 0) begin
            $display("%0t: unexpected result new_bits=%h", $time, got);
            errors++;
            return;
         end
         want = pending_bits.pop_front();
         if (got !== want) begin
            $display("%0t: new_bits mismatch expected=%h actual=%h", $time, want, got);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [31:0] req_last_bits;
   logic [31:0] req_last_block_time;
   logic [31:0] req_first_block_time;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [31:0] rsp_new_bits;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [63:0] csr_wdata;

   retarget_scoreboard sb;
   int     stall_pct;
   int     hold_cycles;
   longint cycle_count;

   difficulty_retarget u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_push             (req_push),
      .req_full             (req_full),
      .req_last_bits        (req_last_bits),
      .req_last_block_time  (req_last_block_time),
      .req_first_block_time (req_first_block_time),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_new_bits         (rsp_new_bits),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > MAX_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // result side: random stalls plus an optional long hold-off
   initial begin
      rsp_pop = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) sb.check(rsp_new_bits);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_pop <= 1'b0;
         end else if (stall_pct == 0) begin
            rsp_pop <= 1'b1;
         end else begin
            rsp_pop <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task automatic send(logic [31:0] bits, logic [31:0] last_t, logic [31:0] first_t);
      req_push             <= 1'b1;
      req_last_bits        <= bits;
      req_last_block_time  <= last_t;
      req_first_block_time <= first_t;
      do @(posedge clock); while (req_full);
      sb.note(bits, last_t, first_t);
   endtask

   task automatic idle_req(int n);
      req_push <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      req_push <= 1'b0;
      while (sb.pending_bits.size() != 0) @(posedge clock);
      repeat (BACK_LAT) @(posedge clock);
   endtask

   task automatic configure(bit nr, logic [29:0] ts, logic [255:0] lim);
      logic [63:0] vals[6];
      logic [2:0]  idx[6];
      vals = '{64'(nr), 64'(ts), lim[63:0], lim[127:64], lim[191:128], lim[255:192]};
      idx  = '{CSR_NO_RETARGET, CSR_TIMESPAN, CSR_LIMIT_0, CSR_LIMIT_1,
               CSR_LIMIT_2, CSR_LIMIT_3};
      for (int i = 0; i < 6; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      // unused index, must be ignored
      csr_index <= CSR_UNUSED;
      csr_wdata <= '1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.no_retarget = nr;
      sb.timespan    = ts;
      sb.limit       = lim;
   endtask

   function automatic logic [31:0] rand_bits();
      logic [31:0] m;
      m = $urandom;
      case ($urandom_range(3))
         0: m[31:24] = 8'($urandom_range(0, 4));
         1: m[31:24] = 8'($urandom_range(28, 36));
         2: m[31:24] = 8'($urandom_range(4, 32));
         default: ;
      endcase
      return m;
   endfunction

   task automatic random_phase(int n);
      logic [31:0] first_t;
      logic [31:0] last_t;
      longint      ts64;
      int          left;
      ts64 = longint'(sb.timespan);
      left = n;
      while (left > 0) begin
         for (int b = $urandom_range(1, 8); b > 0 && left > 0; b--) begin
            first_t = $urandom;
            case ($urandom_range(3))
               0: last_t = $urandom;
               1: last_t = first_t - 32'($urandom_range(0, 1000));
               default: last_t = first_t + 32'((ts64 * $urandom_range(0, 500)) / 100);
            endcase
            send(rand_bits(), last_t, first_t);
            left--;
         end
         if ($urandom_range(3) != 0) idle_req($urandom_range(1, 300));
      end
   endtask

   logic [255:0] full_lim;
   logic [255:0] rnd_lim;

   initial begin
      sb = new();
      stall_pct   = 0;
      hold_cycles = 0;
      reset     = 1'b1;
      req_push  = 1'b0;
      req_last_bits        = '0;
      req_last_block_time  = '0;
      req_first_block_time = '0;
      csr_wr_en = 1'b0;
      csr_index = CSR_NO_RETARGET;
      csr_wdata = '0;
      full_lim  = {64'h0000_0000_ffff_ffff, {192{1'b1}}};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset settings
      send(32'h0000_0000, 32'd7200, 32'd0);
      send(32'hffff_ffff, 32'hffff_ffff, 32'd0);
      send(32'h1d00_ffff, 32'd1000, 32'd2000);
      send(32'h1d00_ffff, 32'd5000, 32'd5000);
      send(32'h0312_3456, 32'd14400, 32'd0);
      send(32'h0212_3456, 32'd3600, 32'd0);
      send(32'h0100_3456, 32'd7200, 32'd0);
      send(32'h0012_3456, 32'd7200, 32'd0);
      send(32'h0492_3456, 32'd9000, 32'd0);
      send(32'h22ff_ffff, 32'd28800, 32'd0);
      send(32'h23ff_ffff, 32'd28800, 32'd0);
      send(32'h217f_ffff, 32'd28800, 32'd0);
      send(32'h207f_ffff, 32'hffff_ffff, 32'd0);
      send(32'h1c7f_ffff, 32'd0, 32'hffff_ffff);
      drain();

      configure(1'b1, 30'd7200, full_lim);
      send(32'h1d00_ffff, 32'd0, 32'd100);
      send(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      send(32'h0000_0000, 32'd0, 32'd0);
      drain();

      configure(1'b0, 30'd0, full_lim);
      send(32'h1d00_ffff, 32'd500, 32'd0);
      send(32'h0000_0000, 32'd0, 32'd0);
      drain();

      configure(1'b0, 30'h3fff_ffff, {256{1'b1}});
      send(32'h227f_ffff, 32'hffff_ffff, 32'd0);
      send(32'h2200_0001, 32'hffff_ffff, 32'd0);
      drain();

      // random phases across settings
      stall_pct = 30;
      configure(1'b0, 30'd7200, full_lim);
      random_phase(150);
      drain();

      // long hold-off so the queue fills and full rises
      hold_cycles = 3000;
      random_phase(60);
      drain();

      stall_pct = 0;
      configure(1'b0, 30'd4, full_lim);
      random_phase(120);
      drain();

      stall_pct = 60;
      configure(1'b0, 30'h3fff_ffff, {256{1'b1}});
      random_phase(120);
      drain();

      stall_pct = 10;
      configure(1'b0, 30'd3, '0);
      random_phase(60);
      drain();

      configure(1'b0, 30'd1, full_lim);
      random_phase(60);
      drain();

      for (int k = 0; k < 4; k++) begin
         rnd_lim = {$urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom};
         rnd_lim = rnd_lim >> $urandom_range(0, 200);
         stall_pct = $urandom_range(0, 70);
         configure(1'b0, 30'($urandom_range(4, 100000)), rnd_lim);
         random_phase(80);
         drain();
      end

      configure(1'b0, 30'($urandom), full_lim);
      random_phase(80);
      drain();

      configure(1'b1, 30'd7200, full_lim);
      random_phase(80);
      drain();

      configure(1'b0, 30'd0, {$urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom, $urandom});
      random_phase(40);
      drain();

      configure(1'b0, 30'd7200, full_lim);
      random_phase(50);
      drain();

      if (sb.errors == 0 && sb.pending_bits.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
